// ===== rtl/d8w_pkg.sv =====
// Shared types and constants for the Daubechies D8 2D wavelet block.
// Holds the filter taps, command codes and host control struct.
package d8w_pkg;

  localparam int SMP_W   = 16;
  localparam int RP_W    = 18;
  localparam int COEF_W  = 20;
  localparam int TAP_W   = 16;
  localparam int ACC_W   = 38;
  localparam int TAP_N   = 8;
  localparam int RND_SH  = 15;

  localparam logic [1:0] FUNC_WR  = 2'd0;
  localparam logic [1:0] FUNC_RUN = 2'd1;
  localparam logic [1:0] FUNC_RD  = 2'd2;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic signed [TAP_W-1:0] LO_TAP [TAP_N] = '{
    16'sd7549, 16'sd23424, 16'sd20673, -16'sd917,
    -16'sd6129, 16'sd1011, 16'sd1078, -16'sd347
  };
  localparam logic signed [TAP_W-1:0] HI_TAP [TAP_N] = '{
    -16'sd347, -16'sd1078, 16'sd1011, 16'sd6129,
    -16'sd917, -16'sd20673, 16'sd23424, -16'sd7549
  };

  typedef struct packed {
    logic smp_we;
    logic coef_re;
    logic start;
  } host_ctl_t;

endpackage

// ===== rtl/d8w_mac.sv =====
// Dual 8-tap multiply-accumulate with Q15 round-to-nearest and saturation.
// Depends on d8w_pkg for taps and widths.
module d8w_mac import d8w_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     in_v,
  input  logic signed [RP_W-1:0]   x,
  input  logic [2:0]               k,
  input  logic                     pass,
  output logic signed [COEF_W-1:0] lo_res,
  output logic signed [COEF_W-1:0] hi_res
);

  localparam int Q_W = ACC_W - RND_SH;
  localparam int P_W = RP_W + TAP_W;

  logic                    p_v_r;
  logic signed [P_W-1:0]   plo_r, phi_r;
  logic signed [ACC_W-1:0] alo_r, ahi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    plo_r <= x * LO_TAP[k];
    phi_r <= x * HI_TAP[k];
    if (clr) begin
      alo_r <= '0;
      ahi_r <= '0;
    end else if (p_v_r) begin
      alo_r <= alo_r + ACC_W'(plo_r);
      ahi_r <= ahi_r + ACC_W'(phi_r);
    end
  end

  function automatic logic signed [COEF_W-1:0] rnd_sat(
    input logic signed [ACC_W-1:0] a,
    input logic                    p
  );
    logic signed [ACC_W-1:0] t;
    logic signed [Q_W-1:0]   q;
    logic signed [Q_W-1:0]   hi_lim, lo_lim;
    t = a + ACC_W'(16384);
    q = t[ACC_W-1:RND_SH];
    hi_lim = p ? Q_W'(524287) : Q_W'(131071);
    lo_lim = -hi_lim - Q_W'(1);
    if (q > hi_lim) q = hi_lim;
    if (q < lo_lim) q = lo_lim;
    return COEF_W'(q);
  endfunction

  assign lo_res = rnd_sat(alo_r, pass);
  assign hi_res = rnd_sat(ahi_r, pass);

endmodule

// ===== rtl/d8w_engine.sv =====
// Sample, row-pass and coefficient memories with the transform sequencer.
// Depends on d8w_pkg and d8w_mac.
module d8w_engine import d8w_pkg::*; #(
  parameter int RW = 6,
  parameter int CW = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  host_ctl_t                ctl,
  input  logic [RW-1:0]            h_row,
  input  logic [CW-1:0]            h_col,
  input  logic signed [SMP_W-1:0]  h_smp,
  output logic signed [COEF_W-1:0] coef_q,
  input  logic [RW-1:0]            rows_m1,
  input  logic [RW-1:0]            rows_half,
  input  logic [CW-1:0]            cols_m1,
  input  logic [CW-1:0]            cols_half,
  output logic                     done
);

  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int LW    = (RW > CW) ? RW : CW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WLO   = 3'd3;
  localparam logic [2:0] S_WHI   = 3'd4;

  logic signed [SMP_W-1:0]  smp_mem  [DEPTH];
  logic signed [RP_W-1:0]   rp_mem   [DEPTH];
  logic signed [COEF_W-1:0] coef_mem [DEPTH];

  logic [2:0]    st_r, st_nxt;
  logic          pass_r, pass_nxt;
  logic [LW-1:0] line_r, line_nxt, pos_r, pos_nxt;
  logic [2:0]    k_r, k_nxt, k_d_r;
  logic          dr_r;
  logic          d_v_r;
  logic          done_nxt, done_r;

  logic signed [SMP_W-1:0] smp_q_r;
  logic signed [RP_W-1:0]  rp_q_r;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [LW+3:0]           tap_idx;
  logic [RW-1:0]           r_wrap;
  logic [CW-1:0]           c_wrap;
  logic signed [RP_W-1:0]  mac_x;
  logic signed [COEF_W-1:0] lo_res, hi_res;
  logic                    pos_last, line_last, wr_en;

  assign tap_idx = (LW+4)'(pos_r) * (LW+4)'(2) + (LW+4)'(k_r);
  assign r_wrap  = RW'(tap_idx) & rows_m1;
  assign c_wrap  = CW'(tap_idx) & cols_m1;
  assign rd_addr = pass_r ? {r_wrap, CW'(line_r)} : {RW'(line_r), c_wrap};

  always_comb begin
    if (!pass_r) begin
      if (st_r == S_WLO) begin
        wr_addr = {RW'(line_r), CW'(pos_r)};
      end else begin
        wr_addr = {RW'(line_r), CW'(pos_r) + cols_half};
      end
    end else begin
      if (st_r == S_WLO) begin
        wr_addr = {RW'(pos_r), CW'(line_r)};
      end else begin
        wr_addr = {RW'(pos_r) + rows_half, CW'(line_r)};
      end
    end
  end

  assign wr_en = (st_r == S_WLO) || (st_r == S_WHI);

  always_ff @(posedge clk) begin
    if (ctl.smp_we) begin
      smp_mem[{h_row, h_col}] <= h_smp;
    end
    smp_q_r <= smp_mem[rd_addr];
    if (wr_en && !pass_r) begin
      rp_mem[wr_addr] <= (st_r == S_WLO) ? RP_W'(lo_res) : RP_W'(hi_res);
    end
    rp_q_r <= rp_mem[rd_addr];
    if (wr_en && pass_r) begin
      coef_mem[wr_addr] <= (st_r == S_WLO) ? lo_res : hi_res;
    end
    if (ctl.coef_re) begin
      coef_q <= coef_mem[{h_row, h_col}];
    end
  end

  assign mac_x = pass_r ? rp_q_r : RP_W'(smp_q_r);

  d8w_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    ((st_r == S_IDLE) || (st_r == S_WHI)),
    .in_v   (d_v_r),
    .x      (mac_x),
    .k      (k_d_r),
    .pass   (pass_r),
    .lo_res (lo_res),
    .hi_res (hi_res)
  );

  assign pos_last  = pass_r ? (RW'(pos_r) == rows_half - RW'(1))
                            : (CW'(pos_r) == cols_half - CW'(1));
  assign line_last = pass_r ? (CW'(line_r) == cols_m1) : (RW'(line_r) == rows_m1);

  always_comb begin
    st_nxt   = st_r;
    pass_nxt = pass_r;
    line_nxt = line_r;
    pos_nxt  = pos_r;
    k_nxt    = k_r;
    done_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (ctl.start) begin
          st_nxt   = S_ISSUE;
          pass_nxt = 1'b0;
          line_nxt = '0;
          pos_nxt  = '0;
          k_nxt    = '0;
        end
      end
      S_ISSUE: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd7) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (dr_r) begin
          st_nxt = S_WLO;
        end
      end
      S_WLO: begin
        st_nxt = S_WHI;
      end
      S_WHI: begin
        st_nxt = S_ISSUE;
        k_nxt  = '0;
        if (!pos_last) begin
          pos_nxt = pos_r + LW'(1);
        end else begin
          pos_nxt = '0;
          if (!line_last) begin
            line_nxt = line_r + LW'(1);
          end else begin
            line_nxt = '0;
            if (!pass_r) begin
              pass_nxt = 1'b1;
            end else begin
              st_nxt   = S_IDLE;
              done_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      d_v_r  <= 1'b0;
      dr_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      d_v_r  <= (st_r == S_ISSUE);
      dr_r   <= (st_r == S_DRAIN) && !dr_r;
    end
  end

  always_ff @(posedge clk) begin
    pass_r <= pass_nxt;
    line_r <= line_nxt;
    pos_r  <= pos_nxt;
    k_r    <= k_nxt;
    k_d_r  <= k_r;
  end

  assign done = done_r;

endmodule

// ===== rtl/daubechies8_2d_wavelet.sv =====
// Top level: stream handshake, size registers and result staging.
// Depends on d8w_pkg and d8w_engine.
// Write/read: pending then output register; one per cycle when idle, out_tready high.
// Run: each output pair takes 8 sequential memory reads through the shared
// MAC, then a drain state and two write states, low then high.
// Reset clears control and sets both size registers to 6; memories are undefined.
module daubechies8_2d_wavelet import d8w_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // func[1:0], row[7:2], col[13:8], sample[29:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // value[19:0], status[20]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RLG   = $clog2(MAX_ROWS + 1) - 1;
  localparam int CLG   = $clog2(MAX_COLS + 1) - 1;
  localparam int RXW   = (RW > 6) ? RW : 6;
  localparam int CXW   = (CW > 6) ? CW : 6;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [2:0] rows_log2_r, cols_log2_r;
  logic [2:0] rlg, clg;
  logic [RW:0] rsize;
  logic [CW:0] csize;
  logic [RW-1:0] rows_m1;
  logic [CW-1:0] cols_m1;

  logic [1:0]  func;
  logic [5:0]  row, col;
  logic signed [SMP_W-1:0] sample;
  logic        bad, acc_in, move, pend_free, done;
  logic [1:0]  st_r, st_nxt;
  logic        pend_r, pend_rd_r, pend_st_r;
  logic        out_v_r, out_st_r;
  logic signed [COEF_W-1:0] out_val_r, coef_q;
  host_ctl_t   ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_log2_r <= 3'd6;
      cols_log2_r <= 3'd6;
    end else if (cfg_we) begin
      if (cfg_index == CFG_COLS) begin
        cols_log2_r <= cfg_wdata;
      end else begin
        rows_log2_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    rlg = (rows_log2_r == 3'd0) ? 3'd1 : rows_log2_r;
    clg = (cols_log2_r == 3'd0) ? 3'd1 : cols_log2_r;
    if (int'(rlg) > RLG) rlg = 3'(RLG);
    if (int'(clg) > CLG) clg = 3'(CLG);
  end

  assign rsize   = (RW+1)'(1) << rlg;
  assign csize   = (CW+1)'(1) << clg;
  assign rows_m1 = RW'(rsize - (RW+1)'(1));
  assign cols_m1 = CW'(csize - (CW+1)'(1));

  assign func   = in_tdata[1:0];
  assign row    = in_tdata[7:2];
  assign col    = in_tdata[13:8];
  assign sample = in_tdata[29:14];

  assign bad = (RXW'(row) > RXW'(rows_m1)) || (CXW'(col) > CXW'(cols_m1));

  assign move      = pend_r && (!out_v_r || out_tready);
  assign pend_free = !pend_r || move;
  assign in_tready = (st_r == ST_IDLE) && pend_free;
  assign acc_in    = in_tvalid && in_tready;

  assign ctl.smp_we  = acc_in && (func == FUNC_WR) && !bad;
  assign ctl.coef_re = acc_in && (func == FUNC_RD) && !bad;
  assign ctl.start   = acc_in && (func == FUNC_RUN);

  d8w_engine #(.RW(RW), .CW(CW)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .h_row     (RW'(row)),
    .h_col     (CW'(col)),
    .h_smp     (sample),
    .coef_q    (coef_q),
    .rows_m1   (rows_m1),
    .rows_half (rsize[RW:1]),
    .cols_m1   (cols_m1),
    .cols_half (csize[CW:1]),
    .done      (done)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (ctl.start) st_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (done) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (pend_free) st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      pend_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if ((acc_in && (func != FUNC_RUN)) || ((st_r == ST_FIN) && pend_free)) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && (func != FUNC_RUN)) begin
      pend_rd_r <= ctl.coef_re;
      pend_st_r <= bad && ((func == FUNC_WR) || (func == FUNC_RD));
    end else if ((st_r == ST_FIN) && pend_free) begin
      pend_rd_r <= 1'b0;
      pend_st_r <= 1'b0;
    end
    if (move) begin
      out_val_r <= pend_rd_r ? coef_q : '0;
      out_st_r  <= pend_st_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_st_r, out_val_r};

endmodule

// ===== test/daubechies8_2d_wavelet_checker.sv =====
// Checker for the D8 2D wavelet block: watches the input, config and result channels.
// Predicts every result from its own copy of the sample, row-pass and coefficient stores.
// Depends on d8w_pkg for the command codes and filter widths.
module daubechies8_2d_wavelet_checker import d8w_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic signed [COEF_W-1:0] value;
    logic                     status;
  } coef_res_t;

  logic [2:0] rows_lg, cols_lg;
  logic signed [SMP_W-1:0]  smp_mem  [0:63][0:63];
  logic signed [RP_W-1:0]   rp_mem   [0:63][0:63];
  logic signed [COEF_W-1:0] coef_mem [0:63][0:63];
  coef_res_t expected_q [$];
  int err_cnt = 0;

  function automatic int dim_of(logic [2:0] lg);
    if (lg == 3'd0) return 2;
    if (lg == 3'd7) return 64;
    return 1 << lg;
  endfunction

  function automatic longint round_sat(longint acc, int bits);
    longint v, hi;
    v = (acc + 64'sd16384) >>> 15;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v;
  endfunction

  task automatic transform_2d();
    int nr, nc;
    longint lo, hi, x;
    nr = dim_of(rows_lg);
    nc = dim_of(cols_lg);
    for (int r = 0; r < nr; r++) begin
      for (int i = 0; i < nc / 2; i++) begin
        lo = 0;
        hi = 0;
        for (int k = 0; k < TAP_N; k++) begin
          x = smp_mem[r][(2 * i + k) % nc];
          lo += x * LO_TAP[k];
          hi += x * HI_TAP[k];
        end
        rp_mem[r][i] = RP_W'(round_sat(lo, RP_W));
        rp_mem[r][i + nc / 2] = RP_W'(round_sat(hi, RP_W));
      end
    end
    for (int i = 0; i < nr / 2; i++) begin
      for (int c = 0; c < nc; c++) begin
        lo = 0;
        hi = 0;
        for (int k = 0; k < TAP_N; k++) begin
          x = rp_mem[(2 * i + k) % nr][c];
          lo += x * LO_TAP[k];
          hi += x * HI_TAP[k];
        end
        coef_mem[i][c] = COEF_W'(round_sat(lo, COEF_W));
        coef_mem[i + nr / 2][c] = COEF_W'(round_sat(hi, COEF_W));
      end
    end
  endtask

  always @(posedge clk) begin
    logic [1:0] f;
    logic [5:0] r, c;
    logic bad;
    coef_res_t e, got;
    if (!rst_n) begin
      rows_lg = 3'd6;
      cols_lg = 3'd6;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) rows_lg = cfg_wdata;
        else cols_lg = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        f = in_tdata[1:0];
        r = in_tdata[7:2];
        c = in_tdata[13:8];
        bad = (r >= dim_of(rows_lg)) || (c >= dim_of(cols_lg));
        e = '0;
        if (f == FUNC_WR) begin
          if (bad) e.status = 1'b1;
          else smp_mem[r][c] = in_tdata[29:14];
        end else if (f == FUNC_RUN) begin
          transform_2d();
        end else if (f == FUNC_RD) begin
          if (bad) e.status = 1'b1;
          else e.value = coef_mem[r][c];
        end
        expected_q.push_back(e);
      end
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[19:0];
        got.status = out_tdata[20];
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("checker: result with none expected: value %0d status %0d",
                     got.value, got.status);
        end else begin
          e = expected_q.pop_front();
          if (got.value !== e.value) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("checker: value mismatch: expected %0d, got %0d", e.value, got.value);
          end
          if (got.status !== e.status) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("checker: status mismatch: expected %0d, got %0d",
                       e.status, got.status);
          end
        end
      end
    end
    pending <= expected_q.size();
    fails <= err_cnt;
  end

endmodule

// ===== test/tb_daubechies8_2d_wavelet.sv =====
// Testbench top for the D8 2D wavelet block: drives commands and size registers.
// Results are checked by daubechies8_2d_wavelet_checker; depends on d8w_pkg.
module tb_daubechies8_2d_wavelet;
  import d8w_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] FUNC_NOP = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  int fails, pending;

  int in_idle = 15;
  int out_idle = 65;
  int sent = 0;
  int stall_cnt = 0;
  int n_rows = 64, n_cols = 64;
  bit coef_ok [0:63][0:63];

  daubechies8_2d_wavelet uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  daubechies8_2d_wavelet_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) out_tready <= ($urandom_range(99) >= out_idle);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("tb_daubechies8_2d_wavelet: done, errors");
      $finish;
    end
  end

  function automatic int dim_of(logic [2:0] lg);
    if (lg == 3'd0) return 2;
    if (lg == 3'd7) return 64;
    return 1 << lg;
  endfunction

  task automatic send_cmd(logic [1:0] f, logic [5:0] r, logic [5:0] c, logic [15:0] s);
    if (sent < ITEM_TARGET / 3) begin
      in_idle = 15;
      out_idle = 65;
    end else if (sent < 2 * ITEM_TARGET / 3) begin
      in_idle = 65;
      out_idle = 15;
    end else begin
      in_idle = 0;
      out_idle = 0;
    end
    if ($urandom_range(99) < in_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, s, c, r, f};
    do @(posedge clk); while (!in_tready);
    sent++;
    if (f == FUNC_RUN)
      for (int i = 0; i < n_rows; i++)
        for (int j = 0; j < n_cols; j++) coef_ok[i][j] = 1'b1;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_sizes(logic [2:0] rl, logic [2:0] cl);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_wdata <= rl;
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_wdata <= cl;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_rows = dim_of(rl);
    n_cols = dim_of(cl);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // func 3, out-of-range write or read
  task automatic send_noise();
    logic [5:0] r, c;
    r = 6'($urandom);
    c = 6'($urandom);
    if ($urandom_range(2) != 0 && (n_rows < 64 || n_cols < 64)) begin
      if (n_rows < 64 && (n_cols == 64 || $urandom_range(1)))
        r = 6'($urandom_range(63, n_rows));
      else c = 6'($urandom_range(63, n_cols));
      send_cmd($urandom_range(1) ? FUNC_WR : FUNC_RD, r, c, 16'($urandom));
    end else begin
      send_cmd(FUNC_NOP, r, c, 16'($urandom));
    end
  endtask

  task automatic send_read();
    logic [5:0] r, c;
    r = 6'($urandom_range(n_rows - 1));
    c = 6'($urandom_range(n_cols - 1));
    if (coef_ok[r][c]) send_cmd(FUNC_RD, r, c, 16'($urandom));
    else send_noise();
  endtask

  task automatic run_phase();
    logic [2:0] rl, cl;
    do begin
      rl = 3'($urandom_range(7));
      cl = 3'($urandom_range(7));
    end while (dim_of(rl) * dim_of(cl) > 128);
    set_sizes(rl, cl);
    for (int r = 0; r < n_rows; r++)
      for (int c = 0; c < n_cols; c++) begin
        if ($urandom_range(9) == 0) send_noise();
        send_cmd(FUNC_WR, 6'(r), 6'(c), pick_sample());
      end
    send_cmd(FUNC_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
    for (int i = 0; i < n_rows * n_cols; i++) begin
      if ($urandom_range(4) == 0) send_noise();
      else send_read();
    end
    for (int i = 0; i < n_rows * n_cols / 4; i++)
      send_cmd(FUNC_WR, 6'($urandom_range(n_rows - 1)), 6'($urandom_range(n_cols - 1)),
               pick_sample());
    send_cmd(FUNC_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
    for (int i = 0; i < n_rows * n_cols / 2; i++) send_read();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // default 64x64: writes at the corners and unused command code
    send_cmd(FUNC_WR, 6'd0, 6'd0, 16'h8000);
    send_cmd(FUNC_WR, 6'd63, 6'd63, 16'h7fff);
    send_cmd(FUNC_WR, 6'd0, 6'd63, 16'h0000);
    send_cmd(FUNC_WR, 6'd63, 6'd0, 16'hffff);
    send_cmd(FUNC_NOP, 6'd63, 6'd63, 16'hffff);
    send_cmd(FUNC_NOP, 6'd0, 6'd0, 16'h0000);
    // smallest matrix, with out-of-range indices
    set_sizes(3'd1, 3'd1);
    send_cmd(FUNC_WR, 6'd0, 6'd0, 16'h7fff);
    send_cmd(FUNC_WR, 6'd0, 6'd1, 16'h8000);
    send_cmd(FUNC_WR, 6'd1, 6'd0, 16'h8000);
    send_cmd(FUNC_WR, 6'd1, 6'd1, 16'h7fff);
    send_cmd(FUNC_WR, 6'd2, 6'd0, 16'h1234);
    send_cmd(FUNC_WR, 6'd0, 6'd63, 16'h1234);
    send_cmd(FUNC_RD, 6'd63, 6'd1, 16'h0000);
    send_cmd(FUNC_RUN, 6'd0, 6'd0, 16'h0000);
    send_cmd(FUNC_RD, 6'd0, 6'd0, 16'h0000);
    send_cmd(FUNC_RD, 6'd0, 6'd1, 16'h0000);
    send_cmd(FUNC_RD, 6'd1, 6'd0, 16'h0000);
    send_cmd(FUNC_RD, 6'd1, 6'd1, 16'h0000);
    // size register zero acts as one
    set_sizes(3'd0, 3'd0);
    send_cmd(FUNC_WR, 6'd1, 6'd1, 16'h8000);
    send_cmd(FUNC_RUN, 6'd63, 6'd63, 16'hffff);
    send_cmd(FUNC_RD, 6'd1, 6'd1, 16'h0000);
    send_cmd(FUNC_RD, 6'd0, 6'd0, 16'h0000);
    send_cmd(FUNC_RD, 6'd2, 6'd2, 16'h0000);
    while (sent < ITEM_TARGET) run_phase();
    drain_results();
    repeat (10) @(posedge clk);
    if (fails == 0) $display("tb_daubechies8_2d_wavelet: done, clean");
    else $display("tb_daubechies8_2d_wavelet: done, errors");
    $finish;
  end

endmodule
